@@ design/coc_pkg.sv @@
// ----------------------------------------------------------------------------
// coc_pkg
// types, constants and codes shared by the cursor overlay compositor
// ----------------------------------------------------------------------------
package coc_pkg;

	localparam int SHAPE_WORDS     = 4096;
	localparam int MAX_CURSOR_SIDE = 64;

	localparam int SHAPE_AW = $clog2(SHAPE_WORDS);
	localparam int SIDE_W   = $clog2(MAX_CURSOR_SIDE);
	localparam int SAT_W    = $clog2(MAX_CURSOR_SIDE + 1);
	localparam int RH_W     = ((SIDE_W > 7) ? SIDE_W : 7) + 1;
	localparam int CALC_W   = ((RH_W + 10) > (SHAPE_AW + 2)) ? (RH_W + 10) : (SHAPE_AW + 2);

	localparam int COORD_W  = 12;
	localparam int POS_W    = 13;
	localparam int WORD_W   = 32;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] ALPHA_MASK = 32'hFF00_0000;
	localparam logic [WORD_W-1:0] COLOR_MASK = 32'h00FF_FFFF;

	typedef enum logic [1:0] {
		CT_MONO   = 2'd0,
		CT_COLOR  = 2'd1,
		CT_MASKED = 2'd2,
		CT_NONE   = 2'd3
	} cursor_type_t;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_TYPE   = 3'd1,
		REG_LEFT   = 3'd2,
		REG_TOP    = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5,
		REG_PITCH  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [0:0]         op;
		logic [11:0]        shape_index;
		logic [WORD_W-1:0]  shape_word;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [WORD_W-1:0]  pixel_value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] pixel_out;
		logic              cursor_hit;
	} res_t;

endpackage

@@ design/coc_shape_ram.sv @@
// ----------------------------------------------------------------------------
// coc_shape_ram
// cursor shape store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module coc_shape_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [coc_pkg::SHAPE_AW-1:0] waddr,
	input  logic [coc_pkg::WORD_W-1:0]   wdata,
	input  logic                         re,
	input  logic [coc_pkg::SHAPE_AW-1:0] raddr_a,
	input  logic [coc_pkg::SHAPE_AW-1:0] raddr_b,
	output logic [coc_pkg::WORD_W-1:0]   rdata_a,
	output logic [coc_pkg::WORD_W-1:0]   rdata_b
);
	import coc_pkg::*;

	logic [WORD_W-1:0] mem [SHAPE_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ design/cursor_overlay_compositor.sv @@
// ----------------------------------------------------------------------------
// cursor_overlay_compositor
// hardware cursor overlay with monochrome and/xor, color and masked color
// ----------------------------------------------------------------------------
// Takes one request per clock and keeps that rate without gaps while the
// response side does not stall. A pixel request's response is valid once it
// has passed the stages below and is taken at an edge where the response side
// does not stall; a load request writes one shape word and gives no response,
// but occupies one slot. The pipe has four stages:
// hit test, shape address and store read, composite, output register. Stalls
// back up stage by stage, so bubbles are squeezed out and requests keep being
// taken while a finished response waits. The shape store needs no clearing
// after reset; a pixel that reads a never-loaded word gets unspecified shape.
module cursor_overlay_compositor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  coc_pkg::req_t               req,
	output logic                        res_valid,
	input  logic                        res_stall,
	output coc_pkg::res_t               res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [coc_pkg::PADDR_W-1:0] paddr,
	input  logic [coc_pkg::PDATA_W-1:0] pwdata,
	output logic [coc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import coc_pkg::*;

	// configuration
	logic               enable_q;
	cursor_type_t       type_q;
	logic [POS_W-1:0]   left_q;
	logic [POS_W-1:0]   top_q;
	logic [6:0]         width_q;
	logic [7:0]         height_q;
	logic [8:0]         pitch_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			type_q   <= CT_MONO;
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			pitch_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_TYPE:   type_q   <= cursor_type_t'(pwdata[1:0]);
				REG_LEFT:   left_q   <= pwdata[POS_W-1:0];
				REG_TOP:    top_q    <= pwdata[POS_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[6:0];
				REG_HEIGHT: height_q <= pwdata[7:0];
				REG_PITCH:  pitch_q  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ENABLE: prdata = PDATA_W'(enable_q);
			REG_TYPE:   prdata = PDATA_W'(type_q);
			REG_LEFT:   prdata = PDATA_W'(left_q);
			REG_TOP:    prdata = PDATA_W'(top_q);
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_PITCH:  prdata = PDATA_W'(pitch_q);
			default:    prdata = '0;
		endcase
	end

	// pipeline flow control
	logic valid_s1, valid_s2, valid_s3, res_valid_q;
	logic rdy_o, rdy3, rdy2, rdy1;
	logic load_s2;

	assign rdy_o     = !res_valid_q || !res_stall;
	assign rdy3      = !valid_s3 || rdy_o;
	assign rdy2      = !valid_s2 || load_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign req_stall = !rdy1;

	// stage 1: request register
	req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req_valid) begin
			req_s1 <= req;
		end
	end

	// hit test
	logic signed [POS_W:0] col, row;
	logic [SAT_W-1:0]      w_sat, h_sat;
	logic [7:0]            h_raw;
	logic                  hit;

	always_comb begin
		col   = $signed({2'b00, req_s1.pixel_x}) - $signed({left_q[POS_W-1], left_q});
		row   = $signed({2'b00, req_s1.pixel_y}) - $signed({top_q[POS_W-1], top_q});
		h_raw = (type_q == CT_MONO) ? {1'b0, height_q[7:1]} : height_q;
		w_sat = (32'(width_q) > MAX_CURSOR_SIDE) ? SAT_W'(MAX_CURSOR_SIDE) : SAT_W'(width_q);
		h_sat = (32'(h_raw) > MAX_CURSOR_SIDE) ? SAT_W'(MAX_CURSOR_SIDE) : SAT_W'(h_raw);
		hit   = enable_q && (type_q != CT_NONE)
			&& !col[POS_W] && !row[POS_W]
			&& (col[POS_W-1:0] < POS_W'(w_sat))
			&& (row[POS_W-1:0] < POS_W'(h_sat));
	end

	// stage 2: shape address
	logic                hit_s2;
	logic [SIDE_W-1:0]   c_s2, r_s2;
	logic [11:0]         index_s2;
	logic [WORD_W-1:0]   word_s2, pixel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			load_s2  <= (req_s1.op == OP_LOAD);
			hit_s2   <= hit;
			c_s2     <= col[SIDE_W-1:0];
			r_s2     <= row[SIDE_W-1:0];
			index_s2 <= req_s1.shape_index;
			word_s2  <= req_s1.shape_word;
			pixel_s2 <= req_s1.pixel_value;
		end
	end

	logic [RH_W-1:0]   rh;
	logic [RH_W+8:0]   prod_a, prod_b, prod_c;
	logic [CALC_W-1:0] baddr_a, baddr_b, waddr_c;
	logic [SHAPE_AW-1:0] raddr_a, raddr_b;
	logic              rd_en, wr_en;

	always_comb begin
		rh      = RH_W'(r_s2) + RH_W'(height_q[7:1]);
		prod_a  = (RH_W+9)'(r_s2) * (RH_W+9)'(pitch_q);
		prod_b  = (RH_W+9)'(rh) * (RH_W+9)'(pitch_q);
		prod_c  = (RH_W+9)'(r_s2) * (RH_W+9)'(pitch_q[8:2]);
		baddr_a = CALC_W'(prod_a) + CALC_W'(c_s2[SIDE_W-1:3]);
		baddr_b = CALC_W'(prod_b) + CALC_W'(c_s2[SIDE_W-1:3]);
		waddr_c = CALC_W'(prod_c) + CALC_W'(c_s2);
		raddr_a = (type_q == CT_MONO) ? baddr_a[SHAPE_AW+1:2] : waddr_c[SHAPE_AW-1:0];
		raddr_b = baddr_b[SHAPE_AW+1:2];
	end

	assign wr_en = valid_s2 && load_s2;
	assign rd_en = valid_s2 && !load_s2 && rdy3;

	logic [WORD_W-1:0] rdata_a_s3, rdata_b_s3;

	coc_shape_ram u_shape_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (index_s2[SHAPE_AW-1:0]),
		.wdata   (word_s2),
		.re      (rd_en),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a_s3),
		.rdata_b (rdata_b_s3)
	);

	// stage 3: shape data, composite
	logic              hit_s3;
	logic [2:0]        bit_s3;
	logic [1:0]        lane_a_s3, lane_b_s3;
	logic [WORD_W-1:0] pixel_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2 && !load_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hit_s3    <= hit_s2;
			bit_s3    <= c_s2[2:0];
			lane_a_s3 <= baddr_a[1:0];
			lane_b_s3 <= baddr_b[1:0];
			pixel_s3  <= pixel_s2;
		end
	end

	logic [7:0]        and_byte, xor_byte;
	logic              and_bit, xor_bit;
	logic [WORD_W-1:0] result;

	always_comb begin
		and_byte = rdata_a_s3[{lane_a_s3, 3'b000} +: 8];
		xor_byte = rdata_b_s3[{lane_b_s3, 3'b000} +: 8];
		and_bit  = and_byte[~bit_s3];
		xor_bit  = xor_byte[~bit_s3];
		result   = pixel_s3;
		if (hit_s3) begin
			case (type_q)
				CT_MONO: begin
					result = (pixel_s3 & (and_bit ? ALL_ONES : ALPHA_MASK))
						^ (xor_bit ? COLOR_MASK : '0);
				end
				CT_COLOR: begin
					if (rdata_a_s3 != '0) result = rdata_a_s3;
				end
				CT_MASKED: begin
					if ((rdata_a_s3 & ALPHA_MASK) != '0) begin
						result = (pixel_s3 ^ rdata_a_s3) | ALPHA_MASK;
					end else begin
						result = rdata_a_s3 | ALPHA_MASK;
					end
				end
				default: result = pixel_s3;
			endcase
		end
	end

	// output register
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rdy_o) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && valid_s3) begin
			res_q.pixel_out  <= result;
			res_q.cursor_hit <= hit_s3;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ design/coc_checker.sv @@
// ----------------------------------------------------------------------------
// coc_checker
// port-level checks of the cursor overlay compositor
// ----------------------------------------------------------------------------
module coc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  coc_pkg::req_t               req,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  coc_pkg::res_t               res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [coc_pkg::PADDR_W-1:0] paddr,
	input  logic [coc_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready
);
	import coc_pkg::*;

	// shadow of enable and type as seen on the register port
	logic         enable_q;
	cursor_type_t type_q;
	logic         cfg_wr;

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			type_q   <= CT_MONO;
		end else if (cfg_wr) begin
			if (reg_idx_t'(paddr[PADDR_W-1:2]) == REG_ENABLE) enable_q <= pwdata[0];
			if (reg_idx_t'(paddr[PADDR_W-1:2]) == REG_TYPE) type_q <= cursor_type_t'(pwdata[1:0]);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled response dropped or changed");

	a_req_flow: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request dropped or changed");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled while no response is pending");

	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.cursor_hit |-> enable_q && (type_q != CT_NONE))
		else $error("cursor hit reported while drawing is off");

	a_masked_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.cursor_hit && (type_q == CT_MASKED) |-> res.pixel_out[31:24] == 8'hFF)
		else $error("masked color hit without opaque alpha");

endmodule

bind cursor_overlay_compositor coc_checker u_coc_checker (.*);

@@ test/tb_cursor_overlay_compositor.sv @@
// ----------------------------------------------------------------------------
// tb_cursor_overlay_compositor
// self-checking testbench for the hardware cursor overlay
// ----------------------------------------------------------------------------
// Drives load and pixel requests through the valid/stall request channel and
// programs the cursor registers over the APB-style port while the block is
// idle. A local predictor keeps its own copy of the registers and the shape
// store and computes each composited pixel; results are checked in order.
// Directed tests cover passthrough, every and/xor combination, color and
// masked color, clipping at negative edges, size saturation, address wrap
// and position extremes; random phases follow with bursty gaps and stalls.
// ----------------------------------------------------------------------------
module tb_cursor_overlay_compositor;
	import coc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	req_t                req;
	logic                res_valid;
	logic                res_stall;
	res_t                res;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// predictor copy of registers and shape store
	logic                cur_en;
	cursor_type_t        cur_type;
	logic signed [12:0]  cur_left;
	logic signed [12:0]  cur_top;
	logic [6:0]          cur_width;
	logic [7:0]          cur_height;
	logic [8:0]          cur_pitch;
	logic [WORD_W-1:0]   shape_mem [SHAPE_WORDS];
	bit                  shape_loaded [SHAPE_WORDS];
	int                  unloaded_words [$];

	res_t                expected_pixels [$];
	int                  mismatches;
	int                  idle_cycles;
	int                  stall_left;
	bit                  idle_on;

	cursor_overlay_compositor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [WORD_W-1:0] shape_word_at(input int addr);
		int a;
		a = addr & (SHAPE_WORDS - 1);
		if (!shape_loaded[a])
			unloaded_words = {unloaded_words, a};
		return shape_mem[a];
	endfunction

	function automatic logic [7:0] shape_byte_at(input int baddr);
		logic [WORD_W-1:0] w;
		w = shape_word_at(baddr >> 2);
		return 8'(w >> ((baddr & 3) * 8));
	endfunction

	function automatic res_t overlay_pixel(input req_t r);
		res_t              o;
		int                col;
		int                row;
		int                half;
		int                wd;
		int                ht;
		logic [7:0]        bit_sel;
		logic [7:0]        and_bit;
		logic [7:0]        xor_bit;
		logic [WORD_W-1:0] sw;
		o.pixel_out  = r.pixel_value;
		o.cursor_hit = 1'b0;
		if (cur_en && cur_type != CT_NONE) begin
			col  = int'(r.pixel_x) - int'(cur_left);
			row  = int'(r.pixel_y) - int'(cur_top);
			half = int'(cur_height) >> 1;
			wd   = int'(cur_width);
			ht   = (cur_type == CT_MONO) ? half : int'(cur_height);
			if (wd > MAX_CURSOR_SIDE) wd = MAX_CURSOR_SIDE;
			if (ht > MAX_CURSOR_SIDE) ht = MAX_CURSOR_SIDE;
			if (col >= 0 && row >= 0 && col < wd && row < ht) begin
				o.cursor_hit = 1'b1;
				if (cur_type == CT_MONO) begin
					bit_sel = 8'h80 >> (col & 7);
					and_bit = shape_byte_at(row * int'(cur_pitch) + (col >> 3)) & bit_sel;
					xor_bit = shape_byte_at((row + half) * int'(cur_pitch) + (col >> 3)) & bit_sel;
					o.pixel_out = (r.pixel_value & ((and_bit != 0) ? ALL_ONES : ALPHA_MASK))
						^ ((xor_bit != 0) ? COLOR_MASK : '0);
				end else begin
					sw = shape_word_at(row * (int'(cur_pitch) >> 2) + col);
					if (cur_type == CT_COLOR) begin
						if (sw != '0)
							o.pixel_out = sw;
					end else if ((sw & ALPHA_MASK) != '0) begin
						o.pixel_out = (r.pixel_value ^ sw) | ALPHA_MASK;
					end else begin
						o.pixel_out = sw | ALPHA_MASK;
					end
				end
			end
		end
		return o;
	endfunction

	function automatic logic [WORD_W-1:0] rand_shape_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return $urandom() & COLOR_MASK;
			3: return $urandom() | ALPHA_MASK;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_pixel_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_request(input req_t r);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		if (r.op == OP_LOAD) begin
			shape_mem[r.shape_index]    = r.shape_word;
			shape_loaded[r.shape_index] = 1'b1;
		end else begin
			expected_pixels = {expected_pixels, overlay_pixel(r)};
		end
	endtask

	task automatic send_load(input int idx, input logic [WORD_W-1:0] w);
		req_t r;
		r.op          = OP_LOAD;
		r.shape_index = 12'(idx);
		r.shape_word  = w;
		r.pixel_x     = COORD_W'($urandom());
		r.pixel_y     = COORD_W'($urandom());
		r.pixel_value = $urandom();
		send_request(r);
	endtask

	// loads any shape word the pixel would read that was never written
	task automatic send_pixel(input int x, input int y, input logic [WORD_W-1:0] v);
		req_t r;
		int   a;
		r.op          = OP_PIXEL;
		r.shape_index = 12'($urandom());
		r.shape_word  = $urandom();
		r.pixel_x     = COORD_W'(x);
		r.pixel_y     = COORD_W'(y);
		r.pixel_value = v;
		unloaded_words.delete();
		void'(overlay_pixel(r));
		while (unloaded_words.size() != 0) begin
			a = unloaded_words.pop_front();
			if (!shape_loaded[a])
				send_load(a, rand_shape_word());
		end
		send_request(r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		bit rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic configure(input bit en, input cursor_type_t ty, input int left,
		input int top, input int width, input int height, input int pitch);
		wait_idle();
		apb_write(REG_ENABLE, PDATA_W'(en));
		apb_write(REG_TYPE, PDATA_W'(ty));
		apb_write(REG_LEFT, PDATA_W'(left));
		apb_write(REG_TOP, PDATA_W'(top));
		apb_write(REG_WIDTH, PDATA_W'(width));
		apb_write(REG_HEIGHT, PDATA_W'(height));
		apb_write(REG_PITCH, PDATA_W'(pitch));
		psel    <= 1'b0;
		penable <= 1'b0;
		cur_en     = en;
		cur_type   = ty;
		cur_left   = POS_W'(left);
		cur_top    = POS_W'(top);
		cur_width  = 7'(width);
		cur_height = 8'(height);
		cur_pitch  = 9'(pitch);
	endtask

	// registers still at reset: cursor off
	task automatic test_passthrough();
		send_pixel(0, 0, '0);
		send_pixel(4095, 4095, ALL_ONES);
		send_pixel(17, 3000, $urandom());
	endtask

	// and plane word 0, xor plane word 4; all four and/xor combinations
	task automatic test_monochrome();
		configure(1'b1, CT_MONO, 0, 0, 16, 8, 4);
		send_load(0, 32'h0000_FF00);
		send_load(4, 32'h0000_0F0F);
		send_pixel(0, 0, $urandom());
		send_pixel(4, 0, $urandom());
		send_pixel(8, 0, $urandom());
		send_pixel(12, 0, $urandom());
		send_pixel(16, 0, $urandom());
		send_pixel(0, 4, $urandom());
	endtask

	// negative left/top clip into the shape; zero word, alpha set, alpha clear
	task automatic test_color_modes();
		configure(1'b1, CT_COLOR, -2, -3, 8, 8, 16);
		send_load(14, '0);
		send_load(15, 32'h1234_5678);
		send_load(16, 32'h00AB_CDEF);
		send_pixel(0, 0, $urandom());
		send_pixel(1, 0, $urandom());
		configure(1'b1, CT_MASKED, -2, -3, 8, 8, 16);
		send_pixel(0, 0, $urandom());
		send_pixel(1, 0, $urandom());
		send_pixel(2, 0, $urandom());
		configure(1'b1, CT_NONE, -2, -3, 8, 8, 16);
		send_pixel(0, 0, $urandom());
	endtask

	// last shape word, far edges, oversized width and height
	task automatic test_position_extremes();
		configure(1'b1, CT_COLOR, 4032, 4032, 127, 255, 256);
		send_load(4095, $urandom());
		send_pixel(4095, 4095, $urandom());
		send_pixel(4031, 4032, $urandom());
		configure(1'b1, CT_COLOR, -4096, -4096, 64, 128, 256);
		send_pixel(0, 0, $urandom());
		configure(1'b1, CT_MONO, 0, 0, 127, 255, 511);
		send_pixel(64, 0, $urandom());
		send_pixel(63, 63, $urandom());
	endtask

	task automatic test_random_traffic();
		int left;
		int top;
		int width;
		int height;
		int pitch;
		int span_x;
		int span_y;
		int x;
		int y;
		for (int ph = 0; ph < 12; ph++) begin
			left   = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
				: int'($urandom_range(0, 4159)) - 64;
			top    = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
				: int'($urandom_range(0, 4159)) - 64;
			width  = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
			height = ($urandom_range(0, 5) == 0) ? $urandom_range(129, 255) : $urandom_range(0, 128);
			pitch  = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
			if (ph == 2) begin
				width  = 64;
				height = 128;
				pitch  = 256;
			end
			configure($urandom_range(0, 7) != 0, cursor_type_t'(ph % 4), left, top, width, height,
				pitch);
			span_x = (width > MAX_CURSOR_SIDE) ? MAX_CURSOR_SIDE : width;
			span_y = (ph % 4 == 0) ? height >> 1 : height;
			if (span_y > MAX_CURSOR_SIDE) span_y = MAX_CURSOR_SIDE;
			for (int i = 0; i < 70; i++) begin
				idle_on = (ph < 10) && ((i / 25) % 2 == 0);
				case ($urandom_range(0, 9))
					0: send_load($urandom_range(0, 4095), rand_shape_word());
					1: send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
						rand_pixel_value());
					default: begin
						x = int'(cur_left) + int'($urandom_range(0, span_x + 7)) - 4;
						y = int'(cur_top) + int'($urandom_range(0, span_y + 7)) - 4;
						x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
						y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
						send_pixel(x, y, rand_pixel_value());
					end
				endcase
			end
		end
		idle_on = 1'b0;
	endtask

	initial begin
		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req        <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		cur_en     = 1'b0;
		cur_type   = CT_MONO;
		cur_left   = '0;
		cur_top    = '0;
		cur_width  = '0;
		cur_height = '0;
		cur_pitch  = '0;
		mismatches = 0;
		idle_on    = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_monochrome();
		test_color_modes();
		test_position_extremes();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("** cursor_overlay_compositor: PASSED **");
		end else begin
			$display("** cursor_overlay_compositor: FAILED **");
		end
		$finish;
	end

	// response side stall bursts
	initial res_stall = 1'b0;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin
		res_t exp_res;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with no pending pixel, expected none actual %h", $time, res);
				mismatches++;
			end else begin
				exp_res = expected_pixels.pop_front();
				if (exp_res.pixel_out !== res.pixel_out) begin
					$display("%0t: pixel_out mismatch, expected %h actual %h", $time,
						exp_res.pixel_out, res.pixel_out);
					mismatches++;
				end
				if (exp_res.cursor_hit !== res.cursor_hit) begin
					$display("%0t: cursor_hit mismatch, expected %b actual %b", $time,
						exp_res.cursor_hit, res.cursor_hit);
					mismatches++;
				end
			end
		end
	end

	initial idle_cycles = 0;
	always @(negedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** cursor_overlay_compositor: FAILED **");
			$finish;
		end
	end

endmodule

@@ sim.f @@
design/coc_pkg.sv
design/coc_shape_ram.sv
design/cursor_overlay_compositor.sv
design/coc_checker.sv
test/tb_cursor_overlay_compositor.sv
